// ----- design/csstrip_pkg.sv -----
// ----------------------------------------------------------------------------
// csstrip_pkg
// Shared types and character codes for the source comment stripper.
// ----------------------------------------------------------------------------
package csstrip_pkg;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;

  localparam int unsigned QUEUE_DEPTH = 4;

  typedef struct packed {
    logic [7:0] char_in;
    logic       line_end;
  } in_item_t;

  typedef struct packed {
    logic [7:0] char_out;
    logic       out_line_end;
    logic       run_last;
  } out_item_t;

  typedef struct packed {
    logic [1:0] count;
    out_item_t  res0;
    out_item_t  res1;
  } push_t;

endpackage

// ----- design/csstrip_core.sv -----
// ----------------------------------------------------------------------------
// csstrip_core
// Lookahead byte register, string/comment flags and the per-byte rewrite.
// Gives up to two results per accepted byte.
// ----------------------------------------------------------------------------
module csstrip_core
  import csstrip_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     accept,
  input  in_item_t in_data,
  output push_t    push
);

  logic [7:0] held_char_r, held_char_nxt;
  logic       held_valid_r, held_valid_nxt;
  logic       in_str_r, in_str_nxt;
  logic       in_blk_r, in_blk_nxt;
  logic       skip_r, skip_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_char_r  <= '0;
      held_valid_r <= 1'b0;
      in_str_r     <= 1'b0;
      in_blk_r     <= 1'b0;
      skip_r       <= 1'b0;
    end else if (accept) begin
      held_char_r  <= held_char_nxt;
      held_valid_r <= held_valid_nxt;
      in_str_r     <= in_str_nxt;
      in_blk_r     <= in_blk_nxt;
      skip_r       <= skip_nxt;
    end
  end

  always_comb begin
    logic [7:0] c;
    logic [7:0] c2;
    logic [7:0] r;
    logic       le;
    logic       s;
    logic       b;
    logic       cut;
    logic       opn;
    logic       cls;
    logic [1:0] cnt;

    c   = in_data.char_in;
    le  = in_data.line_end;
    c2  = c;
    r   = c;
    s   = in_str_r;
    b   = in_blk_r;
    cut = 1'b0;
    opn = 1'b0;
    cls = 1'b0;
    cnt = 2'd0;

    held_char_nxt  = held_char_r;
    held_valid_nxt = held_valid_r;
    skip_nxt       = skip_r;
    push           = '0;

    if (skip_r) begin
      if (le) begin
        skip_nxt = 1'b0;
      end
    end else begin
      if (held_valid_r) begin
        held_valid_nxt = 1'b0;
        s   = in_str_r ^ (held_char_r == CH_QUOTE);
        cut = (held_char_r == CH_SLASH) && (c == CH_SLASH) && !s && !b;
        opn = (held_char_r == CH_SLASH) && (c == CH_STAR) && !s && !b;
        cls = !opn && (held_char_r == CH_STAR) && (c == CH_SLASH) && b;
        if (cut) begin
          push.res0.char_out     = CH_NL;
          push.res0.out_line_end = 1'b1;
          push.res0.run_last     = 1'b1;
          cnt      = 2'd1;
          skip_nxt = !le;
        end else begin
          if (opn) begin
            b = 1'b1;
          end else if (cls) begin
            b = 1'b0;
          end
          if (cls || (b && held_char_r != CH_NL)) begin
            r = CH_SPACE;
          end else begin
            r = held_char_r;
          end
          push.res0.char_out = r;
          cnt = 2'd1;
          if (opn || cls) begin
            c2 = CH_SPACE;
          end
        end
      end
      if (!cut) begin
        if (le) begin
          s = s ^ (c2 == CH_QUOTE);
          r = (b && c2 != CH_NL) ? CH_SPACE : c2;
          if (cnt == 2'd0) begin
            push.res0.char_out     = r;
            push.res0.out_line_end = 1'b1;
            push.res0.run_last     = 1'b1;
            cnt = 2'd1;
          end else begin
            push.res1.char_out     = r;
            push.res1.out_line_end = 1'b1;
            push.res1.run_last     = 1'b1;
            cnt = 2'd2;
          end
        end else begin
          held_char_nxt  = c2;
          held_valid_nxt = 1'b1;
          if (cnt == 2'd1) begin
            push.res0.run_last = 1'b1;
          end
        end
      end
    end

    in_str_nxt = s;
    in_blk_nxt = b;
    push.count = accept ? cnt : 2'd0;
  end

endmodule

// ----- design/csstrip_outq.sv -----
// ----------------------------------------------------------------------------
// csstrip_outq
// Small result queue: takes up to two results per cycle, sends one per cycle while out_ready is high.
// ----------------------------------------------------------------------------
module csstrip_outq
  import csstrip_pkg::*;
#(
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  input  push_t     push,
  output logic      room,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  out_item_t     mem [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          pop;
  logic [AW-1:0] wr_ptr_p1;

  assign pop       = out_valid && out_ready;
  assign wr_ptr_p1 = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
  assign out_valid = (count_r != '0);
  assign out_data  = mem[rd_ptr_r];
  assign room      = (count_r <= CW'(DEPTH - 2));

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    case (push.count)
      2'd1:    wr_ptr_nxt = wr_ptr_p1;
      2'd2:    wr_ptr_nxt = (wr_ptr_p1 == AW'(DEPTH - 1)) ? '0 : wr_ptr_p1 + AW'(1);
      default: wr_ptr_nxt = wr_ptr_r;
    endcase
    rd_ptr_nxt = rd_ptr_r;
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    end
    count_nxt = count_r + CW'(push.count) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem[wr_ptr_r] <= push.res0;
    end
    if (push.count == 2'd2) begin
      mem[wr_ptr_p1] <= push.res1;
    end
  end

endmodule

// ----- design/source_comment_stripper.sv -----
// ----------------------------------------------------------------------------
// source_comment_stripper
// Removes C-style comments from a byte stream, one byte per transfer.
//
// Input channel in_*: one source byte and a flag on the last byte of a line.
// Output channel out_*: rewritten bytes; out_line_end marks a line's last
// byte, run_last the final result caused by one input transfer.
// A byte that is not the last of its line is held one transfer for
// lookahead, so its result leaves with the next byte of the line; the
// line-ending byte leaves at once, after the held one. Results are queued
// and shown on out_* after the results ahead of them leave.
// One input transfer per cycle is taken while the four-entry result queue
// has room for two results; a transfer gives zero, one or two and the
// output sends one per cycle unless stalled. A line never gives more
// results than it has bytes, so output keeps pace with back-to-back input.
// Reset clears the held byte, the string and comment flags and the queue.
// When the receiver stalls the queue fills and in_ready drops.
// ----------------------------------------------------------------------------
module source_comment_stripper
  import csstrip_pkg::*;
#(
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  push_t push;
  logic  room;
  logic  accept;

  assign in_ready = room;
  assign accept   = in_valid && room;

  csstrip_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .in_data (in_data),
    .push    (push)
  );

  csstrip_outq #(
    .DEPTH (DEPTH)
  ) u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ----- sim/strip_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// strip_checker
// Watches both channels of the source comment stripper, predicts the
// rewritten byte stream from every input transfer and compares each output
// transfer field by field against the oldest predicted result.
// ----------------------------------------------------------------------------
module strip_checker
  import csstrip_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_ready,
  input  in_item_t  in_data,
  input  logic      out_valid,
  input  logic      out_ready,
  input  out_item_t out_data,
  output int        fail_count,
  output int        pending,
  output int        checked
);

  typedef enum logic [1:0] {NEXT_KEEP, NEXT_CUT, NEXT_BLANK} next_act_t;

  logic [7:0] held_char;
  logic       held_valid;
  logic       in_str;
  logic       in_blk;
  logic       skipping;
  out_item_t  stripped_q[$];
  out_item_t  want;

  initial begin
    fail_count = 0;
    checked    = 0;
    pending    = 0;
  end

  task automatic report(string msg);
    fail_count++;
    if (fail_count <= 20) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  function automatic logic [7:0] rewrite_char(input logic [7:0] c, input logic has_next,
                                               input logic [7:0] nxt, output next_act_t act);
    logic [7:0] r;
    r   = c;
    act = NEXT_KEEP;
    if (c == CH_QUOTE) in_str = !in_str;
    if (has_next && c == CH_SLASH && nxt == CH_SLASH && !in_str && !in_blk) begin
      act = NEXT_CUT;
      return CH_NL;
    end
    if (has_next && c == CH_SLASH && nxt == CH_STAR && !in_str && !in_blk) begin
      in_blk = 1'b1;
      act    = NEXT_BLANK;
    end else if (has_next && c == CH_STAR && nxt == CH_SLASH && in_blk) begin
      in_blk = 1'b0;
      act    = NEXT_BLANK;
      return CH_SPACE;
    end
    if (in_blk && c != CH_NL) r = CH_SPACE;
    return r;
  endfunction

  function automatic void predict_stripped(in_item_t it);
    logic [7:0] c;
    logic [7:0] r;
    next_act_t  act;
    out_item_t  batch[2];
    int         n;
    n = 0;
    c = it.char_in;
    if (skipping) begin
      if (it.line_end) skipping = 1'b0;
      return;
    end
    if (held_valid) begin
      held_valid = 1'b0;
      r = rewrite_char(held_char, 1'b1, c, act);
      if (act == NEXT_CUT) begin
        stripped_q.push_back('{char_out: r, out_line_end: 1'b1, run_last: 1'b1});
        skipping = !it.line_end;
        return;
      end
      batch[n] = '{char_out: r, out_line_end: 1'b0, run_last: 1'b0};
      n++;
      if (act == NEXT_BLANK) c = CH_SPACE;
    end
    if (it.line_end) begin
      r = rewrite_char(c, 1'b0, 8'h00, act);
      batch[n] = '{char_out: r, out_line_end: 1'b1, run_last: 1'b0};
      n++;
    end else begin
      held_char  = c;
      held_valid = 1'b1;
    end
    if (n > 0) batch[n-1].run_last = 1'b1;
    for (int i = 0; i < n; i++) stripped_q.push_back(batch[i]);
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      held_char  = '0;
      held_valid = 1'b0;
      in_str     = 1'b0;
      in_blk     = 1'b0;
      skipping   = 1'b0;
      stripped_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (stripped_q.size() == 0) begin
          report($sformatf("unexpected result char_out=0x%02h line_end=%0b",
                           out_data.char_out, out_data.out_line_end));
        end else begin
          want = stripped_q.pop_front();
          if (out_data.char_out !== want.char_out)
            report($sformatf("result %0d char_out 0x%02h, want 0x%02h",
                             checked, out_data.char_out, want.char_out));
          if (out_data.out_line_end !== want.out_line_end)
            report($sformatf("result %0d out_line_end %0b, want %0b",
                             checked, out_data.out_line_end, want.out_line_end));
          if (out_data.run_last !== want.run_last)
            report($sformatf("result %0d run_last %0b, want %0b",
                             checked, out_data.run_last, want.run_last));
          checked++;
        end
      end
      if (in_valid && in_ready) predict_stripped(in_data);
    end
    pending <= stripped_q.size();
  end

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives source text into the comment stripper line by line: a directed
// set of comment, string and cut cases, then random lines rich in
// comment and quote characters. Both channels idle at random, the
// receiver holds off once long enough to back up the input, and the sender
// drains three times. The checker module does the prediction and comparison.
// ----------------------------------------------------------------------------
module testbench;
  import csstrip_pkg::*;

  localparam int LIMIT        = 400000;
  localparam int RANDOM_ITEMS = 900;
  localparam int HOLD_CYCLES  = 300;

  logic      clk;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  int fail_count;
  int pending;
  int checked;
  int hold_len   = 0;
  bit rx_always  = 1'b0;
  bit tx_always  = 1'b0;
  int items_sent = 0;
  int lines_sent = 0;

  source_comment_stripper dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  strip_checker scoreboard (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .fail_count(fail_count),
    .pending   (pending),
    .checked   (checked)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    repeat (LIMIT) @(posedge clk);
    $display("timeout with %0d results outstanding", pending);
    $display("** source_comment_stripper: FAILED **");
    $finish;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] rand_char();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return CH_SLASH;
    if (r < 27) return CH_STAR;
    if (r < 35) return CH_QUOTE;
    if (r < 40) return CH_NL;
    if (r < 45) return CH_SPACE;
    if (r < 85) return 8'($urandom_range(8'h61, 8'h7A));
    return 8'($urandom_range(0, 255));
  endfunction

  // receiver: random stalls, a burst window, and one long hold-off
  initial begin
    int n;
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_len > 0) begin
        n        = hold_len;
        hold_len = 0;
        out_ready <= 1'b0;
        repeat (n) @(posedge clk);
      end else if (rx_always) begin
        out_ready <= 1'b1;
        @(posedge clk);
      end else begin
        n = gap_len();
        if (n > 0) begin
          out_ready <= 1'b0;
          repeat (n) @(posedge clk);
        end
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  task automatic send_byte(logic [7:0] c, logic le);
    int gap;
    in_data  <= '{char_in: c, line_end: le};
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    gap = tx_always ? 0 : gap_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], i == s.len() - 1);
    lines_sent++;
  endtask

  task automatic send_random_line();
    int len;
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
    for (int i = 0; i < len; i++) send_byte(rand_char(), i == len - 1);
    lines_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    int  directed;
    bit  hold_done;
    bit  pause_done;
    hold_done  = 1'b0;
    pause_done = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_text("x//ab");
    send_text("y//");
    send_text("/*/");
    send_text("\"\n*/");
    send_text("//\"");
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h00, 1'b1);
    lines_sent += 2;
    directed = items_sent;
    drain();

    while (items_sent < directed + RANDOM_ITEMS) begin
      if (!hold_done && items_sent >= directed + 250) begin
        hold_len  = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (!pause_done && items_sent >= directed + 650) begin
        drain();
        pause_done = 1'b1;
      end
      tx_always = items_sent >= directed + 420 && items_sent < directed + 520;
      rx_always = tx_always;
      send_random_line();
    end
    tx_always = 1'b0;
    rx_always = 1'b0;

    drain();
    repeat (20) @(posedge clk);
    $display("run covered %0d input transfers over %0d source lines, %0d results checked",
             items_sent, lines_sent, checked);
    $display("including a %0d-cycle receiver hold-off and a drain pause", HOLD_CYCLES);
    if (fail_count == 0) begin
      $display("** source_comment_stripper: PASSED **");
    end else begin
      $display("** source_comment_stripper: FAILED **");
    end
    $finish;
  end

endmodule

// ----- files.f -----
design/csstrip_pkg.sv
design/csstrip_core.sv
design/csstrip_outq.sv
design/source_comment_stripper.sv
sim/strip_checker.sv
sim/testbench.sv
